>>> src/lpcp_pkg.sv
package lpcp_pkg;

    localparam int COORD_BITS = 18;
    localparam int COUNT_BITS = 20;
    localparam int ACC_BITS   = 64;
    localparam int COEF_BITS  = 32;
    localparam int PIX_BITS   = 16;
    localparam int LIM_BITS   = 12;
    localparam int KEPT_BITS  = 20;
    localparam int CFG_BITS   = 64;
    localparam int IDX_BITS   = 3;
    localparam int PROD_BITS  = COEF_BITS + COORD_BITS;
    localparam int STEP_BITS  = 4;
    localparam int CNT_BITS   = 6;
    localparam int MAC_STEPS  = 9;

    localparam logic [IDX_BITS-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_MAX_COLUMN  = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_MAX_ROW     = 3'd7;

    localparam logic [LIM_BITS-1:0] MAX_COLUMN_RESET = 12'd1242;
    localparam logic [LIM_BITS-1:0] MAX_ROW_RESET    = 12'd375;

    typedef struct packed {
        logic                 load;
        logic                 mac;
        logic [STEP_BITS-1:0] step;
        logic                 setup;
        logic                 div;
        logic                 round;
        logic                 emit;
    } lpcp_cmd_t;

    typedef struct packed {
        logic out_free;
    } lpcp_status_t;

    // Form trunc(quotient + 0.5) from magnitude, remainder and sign; saturate.
    function automatic logic [PIX_BITS-1:0] round_sat(
        input logic [ACC_BITS-1:0] q,
        input logic [ACC_BITS-1:0] r,
        input logic [ACC_BITS-1:0] b,
        input logic                neg
    );
        logic              half;
        logic [ACC_BITS:0] m;
        logic [PIX_BITS-1:0] res;
        half = ({r, 1'b0} >= {1'b0, b});
        if (!neg) begin
            m = {1'b0, q} + {{ACC_BITS{1'b0}}, half};
            if (m > (ACC_BITS+1)'(32767))
                res = 16'h7fff;
            else
                res = m[PIX_BITS-1:0];
        end
        else begin
            if (half)
                m = {1'b0, q};
            else if (q == '0)
                m = '0;
            else
                m = {1'b0, q - 64'd1};
            if (m > (ACC_BITS+1)'(32768))
                res = 16'h8000;
            else
                res = 16'd0 - m[PIX_BITS-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/lpcp_if.sv
interface lpcp_point_if
    import lpcp_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         sweep_end;

    modport source (output valid, point_x, point_y, point_z, sweep_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, sweep_end, output ready);
endinterface

interface lpcp_pixel_if
    import lpcp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [PIX_BITS-1:0] pixel_column;
    logic signed [PIX_BITS-1:0] pixel_row;
    logic                       in_image;
    logic [KEPT_BITS-1:0]       kept_so_far;
    logic                       sweep_done;

    modport source (output valid, pixel_column, pixel_row, in_image, kept_so_far,
                    sweep_done, input ready);
    modport sink   (input valid, pixel_column, pixel_row, in_image, kept_so_far,
                    sweep_done, output ready);
endinterface

>>> src/lpcp_ctrl.sv
module lpcp_ctrl
    import lpcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lpcp_status_t status,
    output lpcp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SETUP,
        S_DIV,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else begin
            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (in_valid)
                        state_reg <= S_MAC;
                end
                S_MAC: begin
                    // one extra step drains the last product into its sum
                    if (cnt_reg == CNT_BITS'(MAC_STEPS)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SETUP;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_SETUP: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '1)
                        state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        in_ready  = (state_reg == S_IDLE);
        cmd.load  = (state_reg == S_IDLE) && in_valid;
        cmd.mac   = (state_reg == S_MAC);
        cmd.step  = cnt_reg[STEP_BITS-1:0];
        cmd.setup = (state_reg == S_SETUP);
        cmd.div   = (state_reg == S_DIV);
        cmd.round = (state_reg == S_ROUND);
        cmd.emit  = (state_reg == S_EMIT) && status.out_free;
    end

endmodule

>>> src/lpcp_datapath.sv
module lpcp_datapath
    import lpcp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [IDX_BITS-1:0]          cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic                         sweep_end,
    input  lpcp_cmd_t                    cmd,
    output lpcp_status_t                 status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [PIX_BITS-1:0]   pixel_column,
    output logic signed [PIX_BITS-1:0]   pixel_row,
    output logic                         in_image,
    output logic [KEPT_BITS-1:0]         kept_so_far,
    output logic                         sweep_done
);

    logic [CFG_BITS-1:0] r0c01_reg, r0c23_reg, r1c01_reg, r1c23_reg, r2c01_reg, r2c23_reg;
    logic [LIM_BITS-1:0] max_col_reg, max_row_reg;

    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic                         last_reg;
    logic [ACC_BITS-1:0]          u_reg, v_reg, d_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic [1:0]                   tgt_reg;

    logic [ACC_BITS-1:0] qu_reg, qv_reg, ru_reg, rv_reg, b_reg;
    logic                neg_u_reg, neg_v_reg, dzero_reg;

    logic signed [PIX_BITS-1:0] col_reg, row_reg;
    logic                       inside_reg;
    logic [COUNT_BITS-1:0]      kept_reg;
    logic                       out_valid_reg;

    logic signed [COEF_BITS-1:0]  mul_coef;
    logic signed [COORD_BITS-1:0] mul_coord;
    logic [1:0]                   mul_tgt;
    logic [ACC_BITS-1:0]          prod_ext;
    logic [ACC_BITS:0]            ru_sh, rv_sh;
    logic [PIX_BITS-1:0]          col_next, row_next;
    logic                         inside_next;

    // Operand select for the shared multiplier
    always_comb begin
        mul_coef  = '0;
        mul_coord = '0;
        mul_tgt   = 2'd0;
        case (cmd.step)
            4'd0: begin mul_coef = r0c01_reg[31:0];  mul_coord = x_reg; mul_tgt = 2'd0; end
            4'd1: begin mul_coef = r0c01_reg[63:32]; mul_coord = y_reg; mul_tgt = 2'd0; end
            4'd2: begin mul_coef = r0c23_reg[31:0];  mul_coord = z_reg; mul_tgt = 2'd0; end
            4'd3: begin mul_coef = r1c01_reg[31:0];  mul_coord = x_reg; mul_tgt = 2'd1; end
            4'd4: begin mul_coef = r1c01_reg[63:32]; mul_coord = y_reg; mul_tgt = 2'd1; end
            4'd5: begin mul_coef = r1c23_reg[31:0];  mul_coord = z_reg; mul_tgt = 2'd1; end
            4'd6: begin mul_coef = r2c01_reg[31:0];  mul_coord = x_reg; mul_tgt = 2'd2; end
            4'd7: begin mul_coef = r2c01_reg[63:32]; mul_coord = y_reg; mul_tgt = 2'd2; end
            4'd8: begin mul_coef = r2c23_reg[31:0];  mul_coord = z_reg; mul_tgt = 2'd2; end
            default: begin
                mul_coef  = '0;
                mul_coord = '0;
                mul_tgt   = 2'd0;
            end
        endcase
    end

    assign prod_ext = ACC_BITS'(prod_reg);
    assign ru_sh    = {ru_reg, qu_reg[ACC_BITS-1]};
    assign rv_sh    = {rv_reg, qv_reg[ACC_BITS-1]};

    always_comb begin
        if (dzero_reg) begin
            col_next    = '0;
            row_next    = '0;
            inside_next = 1'b0;
        end
        else begin
            col_next    = round_sat(qu_reg, ru_reg, b_reg, neg_u_reg);
            row_next    = round_sat(qv_reg, rv_reg, b_reg, neg_v_reg);
            inside_next = !col_next[PIX_BITS-1] && !row_next[PIX_BITS-1]
                          && (col_next <= PIX_BITS'(max_col_reg))
                          && (row_next <= PIX_BITS'(max_row_reg));
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            r0c01_reg   <= '0;
            r0c23_reg   <= '0;
            r1c01_reg   <= '0;
            r1c23_reg   <= '0;
            r2c01_reg   <= '0;
            r2c23_reg   <= '0;
            max_col_reg <= MAX_COLUMN_RESET;
            max_row_reg <= MAX_ROW_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_ROW0_COLS01: r0c01_reg   <= cfg_data;
                REG_ROW0_COLS23: r0c23_reg   <= cfg_data;
                REG_ROW1_COLS01: r1c01_reg   <= cfg_data;
                REG_ROW1_COLS23: r1c23_reg   <= cfg_data;
                REG_ROW2_COLS01: r2c01_reg   <= cfg_data;
                REG_ROW2_COLS23: r2c23_reg   <= cfg_data;
                REG_MAX_COLUMN:  max_col_reg <= cfg_data[LIM_BITS-1:0];
                REG_MAX_ROW:     max_row_reg <= cfg_data[LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Payload path: point load, multiply-accumulate, long division, rounding, output load
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            z_reg    <= point_z;
            last_reg <= sweep_end;
            // seed each sum with its translation coefficient
            u_reg    <= ACC_BITS'(signed'(r0c23_reg[63:32]));
            v_reg    <= ACC_BITS'(signed'(r1c23_reg[63:32]));
            d_reg    <= ACC_BITS'(signed'(r2c23_reg[63:32]));
        end
        if (cmd.mac) begin
            if (cmd.step < STEP_BITS'(MAC_STEPS)) begin
                prod_reg <= mul_coef * mul_coord;
                tgt_reg  <= mul_tgt;
            end
            if (cmd.step != '0) begin
                case (tgt_reg)
                    2'd0:    u_reg <= u_reg + prod_ext;
                    2'd1:    v_reg <= v_reg + prod_ext;
                    default: d_reg <= d_reg + prod_ext;
                endcase
            end
        end
        if (cmd.setup) begin
            neg_u_reg <= u_reg[ACC_BITS-1] ^ d_reg[ACC_BITS-1];
            neg_v_reg <= v_reg[ACC_BITS-1] ^ d_reg[ACC_BITS-1];
            dzero_reg <= (d_reg == '0);
            qu_reg    <= u_reg[ACC_BITS-1] ? (64'd0 - u_reg) : u_reg;
            qv_reg    <= v_reg[ACC_BITS-1] ? (64'd0 - v_reg) : v_reg;
            b_reg     <= d_reg[ACC_BITS-1] ? (64'd0 - d_reg) : d_reg;
            ru_reg    <= '0;
            rv_reg    <= '0;
        end
        if (cmd.div) begin
            // one restoring step per cycle on both numerators
            if (ru_sh >= {1'b0, b_reg}) begin
                ru_reg <= ru_sh[ACC_BITS-1:0] - b_reg;
                qu_reg <= {qu_reg[ACC_BITS-2:0], 1'b1};
            end
            else begin
                ru_reg <= ru_sh[ACC_BITS-1:0];
                qu_reg <= {qu_reg[ACC_BITS-2:0], 1'b0};
            end
            if (rv_sh >= {1'b0, b_reg}) begin
                rv_reg <= rv_sh[ACC_BITS-1:0] - b_reg;
                qv_reg <= {qv_reg[ACC_BITS-2:0], 1'b1};
            end
            else begin
                rv_reg <= rv_sh[ACC_BITS-1:0];
                qv_reg <= {qv_reg[ACC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.round) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            inside_reg <= inside_next;
        end
        if (cmd.emit) begin
            pixel_column <= col_reg;
            pixel_row    <= row_reg;
            in_image     <= inside_reg;
            sweep_done   <= last_reg;
            if (inside_reg && (kept_reg != '1))
                kept_so_far <= KEPT_BITS'(kept_reg + 1'b1);
            else
                kept_so_far <= KEPT_BITS'(kept_reg);
        end
    end

    // Control state: kept counter and output valid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                    kept_reg <= '0;
                else if (inside_reg && (kept_reg != '1))
                    kept_reg <= kept_reg + 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

>>> src/lidar_point_camera_projection.sv
// Steps per word: 10 multiply-accumulate steps on one shared 32x18 multiplier,
// 1 setup, 64 restoring divide steps for column and row in parallel, 1 round,
// 1 load into the output register. The next point is taken only after that load,
// and the divider takes most of the time; a stalled output holds the load back.
// Reset: rst_n asynchronous active low; matrix clears to zero, limits to 1242x375,
// kept counter to zero, output empty.
module lidar_point_camera_projection
    import lpcp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lpcp_point_if.sink          in_ch,
    lpcp_pixel_if.source        out_ch,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    lpcp_cmd_t    cmd;
    lpcp_status_t status;

    // Sequence one word at a time: take a point, multiply, divide, round, emit
    lpcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold matrix, sums, divider and output register; the output register
    // lets a finished word wait while the next point is taken
    lpcp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_x      (in_ch.point_x),
        .point_y      (in_ch.point_y),
        .point_z      (in_ch.point_z),
        .sweep_end    (in_ch.sweep_end),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .pixel_column (out_ch.pixel_column),
        .pixel_row    (out_ch.pixel_row),
        .in_image     (out_ch.in_image),
        .kept_so_far  (out_ch.kept_so_far),
        .sweep_done   (out_ch.sweep_done)
    );

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import lpcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One projected pixel word as it leaves the block.
    typedef struct {
        logic signed [PIX_BITS-1:0] column;
        logic signed [PIX_BITS-1:0] row;
        logic                       in_image;
        logic [KEPT_BITS-1:0]       kept;
        logic                       done;
    } pixel_word_t;

    // Projection predictor and store of expected pixel words.
    class pixel_scoreboard;
        logic [CFG_BITS-1:0]        matrix_regs[6];
        logic [LIM_BITS-1:0]        col_limit;
        logic [LIM_BITS-1:0]        row_limit;
        logic [COUNT_BITS-1:0]      kept_count;
        pixel_word_t                pending_pixels[$];
        int                         mismatches;

        function new();
            foreach (matrix_regs[i])
                matrix_regs[i] = '0;
            col_limit  = MAX_COLUMN_RESET;
            row_limit  = MAX_ROW_RESET;
            kept_count = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_MAX_COLUMN: col_limit = data[LIM_BITS-1:0];
                REG_MAX_ROW:    row_limit = data[LIM_BITS-1:0];
                default:        matrix_regs[idx] = data;
            endcase
        endfunction

        function logic signed [63:0] coef(int r, int c);
            logic [CFG_BITS-1:0]      pair;
            logic signed [COEF_BITS-1:0] w;
            pair = matrix_regs[2*r + c/2];
            w = (c % 2) ? pair[63:32] : pair[31:0];
            return 64'(w);
        endfunction

        // Homogeneous dot product, 64-bit wrapping accumulator.
        function logic signed [63:0] dot_row(int r, logic signed [63:0] x,
                                             logic signed [63:0] y, logic signed [63:0] z);
            return coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z + coef(r, 3);
        endfunction

        // trunc(num/den + 0.5) with saturation to 16 bits.
        function logic signed [PIX_BITS-1:0] round_div(logic signed [63:0] num,
                                                       logic signed [63:0] den);
            logic        neg;
            logic [63:0] a, b, q, r, m;
            logic        half;
            neg = (num < 0) != (den < 0);
            a = (num < 0) ? 64'd0 - num : num;
            b = (den < 0) ? 64'd0 - den : den;
            q = a / b;
            r = a % b;
            half = r >= b - r;
            if (!neg)
            begin
                m = q + 64'(half);
                if (m < q || m > 64'd32767)
                    return 16'sh7fff;
                return m[PIX_BITS-1:0];
            end
            m = half ? q : ((q == 0) ? 64'd0 : q - 64'd1);
            if (m > 64'd32768)
                return 16'sh8000;
            return 16'd0 - m[PIX_BITS-1:0];
        endfunction

        function void note_point(logic signed [COORD_BITS-1:0] px,
                                 logic signed [COORD_BITS-1:0] py,
                                 logic signed [COORD_BITS-1:0] pz, logic last);
            logic signed [63:0] x, y, z, u, v, d;
            pixel_word_t        w;
            x = 64'(px);
            y = 64'(py);
            z = 64'(pz);
            u = dot_row(0, x, y, z);
            v = dot_row(1, x, y, z);
            d = dot_row(2, x, y, z);
            w.column   = '0;
            w.row      = '0;
            w.in_image = 1'b0;
            // zero depth: pixel 0,0 and outside
            if (d != 0)
            begin
                w.column   = round_div(u, d);
                w.row      = round_div(v, d);
                w.in_image = w.column >= 0 && w.row >= 0 &&
                             w.column <= $signed({5'd0, col_limit}) &&
                             w.row <= $signed({5'd0, row_limit});
            end
            if (w.in_image && kept_count != '1)
                kept_count++;
            w.kept = KEPT_BITS'(kept_count);
            w.done = last;
            if (last)
                kept_count = '0;
            pending_pixels = {pending_pixels, w};
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_pixel(pixel_word_t got);
            pixel_word_t want;
            if (pending_pixels.size() == 0)
            begin
                report("unexpected word", 1, 0);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.column !== want.column)     report("pixel_column", got.column, want.column);
            if (got.row !== want.row)           report("pixel_row", got.row, want.row);
            if (got.in_image !== want.in_image) report("in_image", got.in_image, want.in_image);
            if (got.kept !== want.kept)         report("kept_so_far", got.kept, want.kept);
            if (got.done !== want.done)         report("sweep_done", got.done, want.done);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    lpcp_point_if in_ch ();
    lpcp_pixel_if out_ch ();

    lidar_point_camera_projection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_scoreboard sb = new();

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver: stall at random, and check every word taken off the output.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.column   = out_ch.pixel_column;
                got.row      = out_ch.pixel_row;
                got.in_image = out_ch.in_image;
                got.kept     = out_ch.kept_so_far;
                got.done     = out_ch.sweep_done;
                sb.check_pixel(got);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one register write, then wait on the clock; the caller drops cfg_we afterwards.
    task write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Pack two signed Q16.16 coefficients, lower column in the low word.
    function logic [CFG_BITS-1:0] coef_pair(int lo, int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    // Load the whole matrix and both limits; upper data bits of the limits are noise.
    task load_matrix(int fx, int fy, int cx, int cy, int tx, int ty, int tz,
                     int col_max, int row_max);
        write_reg(REG_ROW0_COLS01, coef_pair(fx, 0));
        write_reg(REG_ROW0_COLS23, coef_pair(cx, tx));
        write_reg(REG_ROW1_COLS01, coef_pair(0, fy));
        write_reg(REG_ROW1_COLS23, coef_pair(cy, ty));
        write_reg(REG_ROW2_COLS01, coef_pair(0, 0));
        write_reg(REG_ROW2_COLS23, coef_pair(32'h0001_0000, tz));
        write_reg(REG_MAX_COLUMN, {20'($urandom), 32'($urandom), 12'(col_max)});
        write_reg(REG_MAX_ROW, {20'($urandom), 32'($urandom), 12'(row_max)});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Send one point word; idle first at random, then hold until accepted.
    task send_point(int x, int y, int z, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.point_x   <= COORD_BITS'(x);
        in_ch.point_y   <= COORD_BITS'(y);
        in_ch.point_z   <= COORD_BITS'(z);
        in_ch.sweep_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_point(COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z), last);
    endtask

    // Mostly plausible scene points in front of the sensor, some raw noise.
    task send_random(int count);
        int x, y, z;
        repeat (count)
        begin
            if ($urandom_range(3) == 0)
            begin
                x = $signed(COORD_BITS'($urandom));
                y = $signed(COORD_BITS'($urandom));
                z = $signed(COORD_BITS'($urandom));
            end
            else
            begin
                z = $urandom_range(131071, 300);
                x = int'($urandom_range(2 * z)) - z;
                y = int'($urandom_range(z)) - z / 2;
                if ($urandom_range(15) == 0)
                    z = -z;
            end
            send_point(x, y, z, $urandom_range(39) == 0);
        end
        in_ch.valid <= 1'b0;
    endtask

    // Let every expected word drain, plus slack for the pipeline.
    task drain();
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    initial
    begin
        #4ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.point_x   <= '0;
        in_ch.point_y   <= '0;
        in_ch.point_z   <= '0;
        in_ch.sweep_end <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix is all zero: every point has zero depth.
        send_point(1000, -2000, 5000, 1'b0);
        send_point(131071, -131072, 131071, 1'b1);
        send_random(20);
        drain();

        // Plausible camera, default image size; directed corners first.
        set_idling(1);
        load_matrix(700 << 16, 700 << 16, 620 << 16, 190 << 16, 44 << 16, 0, 0, 1242, 375);
        send_point(0, 0, 10000, 1'b0);              // image center
        send_point(0, 0, -10000, 1'b0);             // negative depth
        send_point(131071, 0, 1, 1'b0);             // column saturates high
        send_point(-131072, -131072, 1, 1'b0);      // saturates low
        send_point(-131072, 131071, 131071, 1'b0);
        send_point(131071, 131071, -131072, 1'b0);
        send_point(0, 0, 0, 1'b0);                  // zero depth
        send_point(-1, -1, 2, 1'b0);                // small negative x and y
        send_point(1, 1, 2, 1'b1);                  // small positive x and y, ends sweep
        send_point(5000, 3000, 20000, 1'b1);        // one-point sweep
        send_random(330);
        drain();

        // Tightest bounds: only pixel 0,0 is inside.
        set_idling(2);
        load_matrix(500 << 16, 500 << 16, 0, 0, 0, 0, 0, 0, 0);
        send_point(0, 0, 1000, 1'b0);
        send_point(1, 0, 1000, 1'b0);
        send_point(-1, 0, 1000, 1'b1);
        send_random(250);
        drain();

        // Widest bounds.
        set_idling(3);
        load_matrix(1200 << 16, 1100 << 16, 2000 << 16, 2000 << 16, 0, 0, 0, 4095, 4095);
        send_point(0, 0, 50000, 1'b0);
        send_random(350);
        drain();

        // Fully random matrix words, random limits.
        set_idling(0);
        foreach (sb.matrix_regs[i])
            write_reg(IDX_BITS'(i), {$urandom, $urandom});
        write_reg(REG_MAX_COLUMN, {$urandom, $urandom});
        write_reg(REG_MAX_ROW, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
        send_random(300);
        drain();

        // Extreme coefficients, then a plausible camera with random limits.
        set_idling(1);
        load_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 4095, 0);
        send_random(150);
        drain();
        set_idling(3);
        load_matrix(721 << 16, 721 << 16, 609 << 16, 172 << 16, -(3 << 16), 5 << 16, 1 << 14,
                    $urandom_range(4095), $urandom_range(4095));
        send_random(350);
        drain();

        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
